[rtl/core/frwl_pkg.sv]
// frwl_pkg: shared types and constants of the fair reader/writer lock unit
// used by the queue cell and the top level; no dependencies

package frwl_pkg;

    localparam int FRWL_QUEUE_DEPTH = 16;
    localparam int FRWL_MAX_RESULTS = 16;
    localparam int FRWL_RES_W       = $clog2(FRWL_MAX_RESULTS + 1);
    localparam int FRWL_ID_W        = 8;
    localparam int FRWL_READERS_W   = 8;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    typedef enum logic [1:0] {
        OP_ACQ_READ  = 2'd0,
        OP_ACQ_WRITE = 2'd1,
        OP_REL_READ  = 2'd2,
        OP_REL_WRITE = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_GRANTED   = 2'd0,
        ST_FULL      = 2'd1,
        ST_NO_HOLDER = 2'd2
    } t_status;

    // one waiting request as held in a queue cell
    typedef struct packed {
        logic                 kind;
        logic [FRWL_ID_W-1:0] id;
    } t_entry;

    // per-cell control from the sequencer
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

[rtl/core/frwl_req_if.sv]
// frwl_req_if: request channel (acquire / release items)
// valid/ready handshake; no dependencies

interface frwl_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] requester_id;

    modport source (output valid, output opcode, output requester_id, input ready);
    modport sink   (input valid, input opcode, input requester_id, output ready);
endinterface

[rtl/core/frwl_res_if.sv]
// frwl_res_if: result channel (grants and error reports)
// valid/ready handshake; no dependencies

interface frwl_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] grant_id;
    logic       grant_kind;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output grant_id, output grant_kind, output status,
                    output last, input ready);
    modport sink   (input valid, input grant_id, input grant_kind, input status,
                    input last, output ready);
endinterface

[rtl/core/fair_reader_writer_lock_unit.sv]
// fair_reader_writer_lock_unit: fifo-fair reader/writer lock manager
// sequencer plus a chain of frwl_cell slots; uses frwl_pkg, frwl_req_if, frwl_res_if
//
// Requests arrive on i_req (opcode, requester_id); results leave on o_res
// (grant_id, grant_kind, status, last). Acquires join a wait queue held in a
// chain of cells, cell 0 being the oldest; a pop moves every entry one cell
// down. After each request the head is granted while admissible, one grant
// per cycle while the output register is free. An error result (queue full,
// release without holder) comes first; last marks the final result of a
// request, and a request that causes nothing produces no result.
// Sequence: accept in S_IDLE, apply the request or report its error in
// S_EXEC, one grant per head in S_GRANT, then a final head check that
// returns to S_IDLE. An error result is loaded into the output register in
// S_EXEC, a grant in S_GRANT. The rate is set by the single head grant per cycle.
// A new request is taken only once the previous one is fully handled, but
// may be accepted while its last result still waits in the output register.
// When the receiver stalls, the sequencer holds until the register frees.
// Reset clears the queue count, the holder state and both handshakes; the
// queue cells need no clearing.

module fair_reader_writer_lock_unit
    import frwl_pkg::*;
#(
    parameter int QUEUE_DEPTH = FRWL_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    frwl_req_if.sink    i_req,
    frwl_res_if.source  o_res
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_GRANT
    } t_state;

    t_state                    r_state, n_state;
    t_opcode                   r_op, n_op;
    logic [FRWL_ID_W-1:0]      r_id, n_id;
    logic [CW-1:0]             r_count, n_count;
    logic [FRWL_READERS_W-1:0] r_readers, n_readers;
    logic                      r_writer, n_writer;
    logic [FRWL_RES_W-1:0]     r_nres, n_nres;
    logic                      r_out_valid, n_out_valid;
    logic [FRWL_ID_W-1:0]      r_out_id, n_out_id;
    logic                      r_out_kind, n_out_kind;
    t_status                   r_out_status, n_out_status;
    logic                      r_out_last, n_out_last;

    t_entry    cell_q [QUEUE_DEPTH];
    t_entry    new_entry;
    t_cell_ctl cell_ctl [QUEUE_DEPTH];
    logic      push, pop;
    logic      slot_free, full, head_ok, next_ok, err, op_kind;

    assign new_entry = '{kind: op_kind, id: r_id};

    // chain of queue cells, cell 0 is the head
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry upper;
        if (g == QUEUE_DEPTH - 1) begin : g_top
            assign upper = '0;
        end else begin : g_mid
            assign upper = cell_q[g+1];
        end
        assign cell_ctl[g].shift = pop;
        assign cell_ctl[g].load  = push && (r_count == CW'(g));
        frwl_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl[g]),
            .i_upper (upper),
            .i_load  (new_entry),
            .o_entry (cell_q[g])
        );
    end

    assign slot_free = !r_out_valid || o_res.ready;
    assign full      = (r_count == CW'(QUEUE_DEPTH));
    assign op_kind   = (r_op == OP_ACQ_WRITE) || (r_op == OP_REL_WRITE);

    // head can be granted with the current holder state
    always_comb begin
        head_ok = (r_count != '0) && !r_writer
                  && (r_nres < FRWL_RES_W'(FRWL_MAX_RESULTS));
        if (cell_q[0].kind == KIND_WRITE) begin
            head_ok = head_ok && (r_readers == '0);
        end else begin
            head_ok = head_ok && (r_readers != '1);
        end
    end

    // second entry can follow a reader grant of the head
    assign next_ok = (r_count > CW'(1)) && (cell_q[1].kind == KIND_READ)
                     && (r_readers != FRWL_READERS_W'(254))
                     && ((r_nres + FRWL_RES_W'(1)) < FRWL_RES_W'(FRWL_MAX_RESULTS));

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_id         = r_id;
        n_count      = r_count;
        n_readers    = r_readers;
        n_writer     = r_writer;
        n_nres       = r_nres;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_id     = r_out_id;
        n_out_kind   = r_out_kind;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        push         = 1'b0;
        pop          = 1'b0;
        err          = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op    = t_opcode'(i_req.opcode);
                    n_id    = i_req.requester_id;
                    n_nres  = '0;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_op)
                    OP_ACQ_READ, OP_ACQ_WRITE: err = full;
                    OP_REL_READ:               err = (r_readers == '0);
                    OP_REL_WRITE:              err = !r_writer;
                    default:                   err = 1'b0;
                endcase
                if (err) begin
                    // state is unchanged, so the head check already holds for after
                    if (slot_free) begin
                        n_out_valid  = 1'b1;
                        n_out_id     = r_id;
                        n_out_kind   = op_kind;
                        n_out_status = (r_op == OP_ACQ_READ || r_op == OP_ACQ_WRITE) ?
                                       ST_FULL : ST_NO_HOLDER;
                        n_out_last   = !head_ok;
                        n_nres       = FRWL_RES_W'(1);
                        n_state      = S_GRANT;
                    end
                end else begin
                    case (r_op)
                        OP_ACQ_READ, OP_ACQ_WRITE: begin
                            push    = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                        OP_REL_READ:  n_readers = r_readers - FRWL_READERS_W'(1);
                        OP_REL_WRITE: n_writer  = 1'b0;
                        default:      n_writer  = r_writer;
                    endcase
                    n_state = S_GRANT;
                end
            end
            S_GRANT: begin
                if (!head_ok) begin
                    n_state = S_IDLE;
                end else if (slot_free) begin
                    pop          = 1'b1;
                    n_count      = r_count - CW'(1);
                    n_nres       = r_nres + FRWL_RES_W'(1);
                    n_out_valid  = 1'b1;
                    n_out_id     = cell_q[0].id;
                    n_out_kind   = cell_q[0].kind;
                    n_out_status = ST_GRANTED;
                    if (cell_q[0].kind == KIND_WRITE) begin
                        n_writer   = 1'b1;
                        n_out_last = 1'b1;
                    end else begin
                        n_readers  = r_readers + FRWL_READERS_W'(1);
                        n_out_last = !next_ok;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_readers   <= '0;
            r_writer    <= 1'b0;
            r_nres      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_readers   <= n_readers;
            r_writer    <= n_writer;
            r_nres      <= n_nres;
            r_out_valid <= n_out_valid;
        end
        r_op         <= n_op;
        r_id         <= n_id;
        r_out_id     <= n_out_id;
        r_out_kind   <= n_out_kind;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_res.valid      = r_out_valid;
    assign o_res.grant_id   = r_out_id;
    assign o_res.grant_kind = r_out_kind;
    assign o_res.status     = r_out_status;
    assign o_res.last       = r_out_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_writer |-> (r_readers == '0))
        else $error("writer active together with readers");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (r_count != '0) && slot_free)
        else $error("pop from empty queue or into busy output");

    a_writer_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && cell_q[0].kind == KIND_WRITE) |=> r_writer && r_out_valid && r_out_last)
        else $error("writer grant did not take the lock");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !i_req.valid) |=> $stable(r_count) && $stable(r_readers))
        else $error("lock state changed while idle");

endmodule

[rtl/core/frwl_cell.sv]
// frwl_cell: one slot of the wait queue chain
// loads a new request or takes the entry of its upper neighbor on a pop; uses frwl_pkg

module frwl_cell
    import frwl_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_upper,
    input  t_entry    i_load,
    output t_entry    o_entry
);

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= i_load;
        end else if (i_ctl.shift) begin
            r_entry <= i_upper;
        end
    end

    assign o_entry = r_entry;

endmodule
